### src/ray_box_slab_test_2d_assert.svh
// assertion macros shared by the ray box slab test rtl
`ifndef RAY_BOX_SLAB_TEST_2D_ASSERT_SVH
`define RAY_BOX_SLAB_TEST_2D_ASSERT_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define RBST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define RBST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/rbst_pkg.sv
`timescale 1ns / 1ps

package rbst_pkg;

   // per-axis status from the slab setup
   typedef struct packed {
      logic parallel;   // direction component is zero
      logic outside;    // parallel and origin outside the closed slab
      logic exit_neg;   // exit numerator below zero
   } axis_flags_type;

   // item status carried alongside the products
   typedef struct packed {
      logic par_x;
      logic par_y;
      logic slab_miss;
      logic clamp_miss;
   } prep_flags_type;

endpackage

### src/ray_box_slab_test_2d.sv
`timescale 1ns / 1ps
`include "ray_box_slab_test_2d_assert.svh"

// Exact 2D ray versus axis-aligned box test by the slab method, on signed
// Q16.16 coordinates. One item (box center, half extents, ray origin and
// direction) can be accepted every clock cycle while the result side does
// not stall. The result passes through a four-stage pipeline, whose first
// stage is loaded at the accepting edge: slab setup, split partial products,
// product sum, then the exact cross-multiplied compares that feed the result
// register. Back-pressure from rsp_ready holds each occupied stage whose
// successor cannot move, while empty stages still fill; nothing is dropped
// or repeated. The clamp register (csr port) makes boxes lying wholly behind
// the origin miss; write it only while no items are in flight.
module ray_box_slab_test_2d
   import rbst_pkg::*;
#(
   parameter int COORD_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic                         csr_clamp_entry_to_origin,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_box_center_x,
   input  logic signed [COORD_BITS-1:0] req_box_center_y,
   input  logic        [COORD_BITS-3:0] req_half_width,
   input  logic        [COORD_BITS-3:0] req_half_height,
   input  logic signed [COORD_BITS-1:0] req_ray_origin_x,
   input  logic signed [COORD_BITS-1:0] req_ray_origin_y,
   input  logic signed [COORD_BITS-1:0] req_ray_dir_x,
   input  logic signed [COORD_BITS-1:0] req_ray_dir_y,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_hit
);

   localparam int NumBits  = COORD_BITS + 2;
   localparam int DenBits  = COORD_BITS;
   localparam int ProdBits = NumBits + DenBits;

   logic clamp_ff;

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, rsp_valid_ff, rsp_valid_in;
   logic adv1, adv2, adv3, adv4;

   logic signed [NumBits-1:0] ent_x, ext_x, ent_y, ext_y;
   logic        [DenBits-1:0] den_x, den_y;
   axis_flags_type            flags_x, flags_y;

   logic signed [NumBits-1:0] ent_x_ff, ext_x_ff, ent_y_ff, ext_y_ff;
   logic        [DenBits-1:0] den_x_ff, den_y_ff;
   prep_flags_type            flags1_in, flags1_ff, flags2_ff, flags3_ff;

   logic signed [ProdBits-1:0] prod_ex_dy, prod_ty_dx, prod_ey_dx, prod_tx_dy;
   logic hit_in, hit_ff;

   // configuration register, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_ff <= 1'b0;
      end else if (csr_valid) begin
         clamp_ff <= csr_clamp_entry_to_origin;
      end
   end

   // stage advance: a stage moves when empty or when the next one moves
   always_comb begin
      adv4         = !rsp_valid_ff || rsp_ready;
      adv3         = !v3_ff || adv4;
      adv2         = !v2_ff || adv3;
      adv1         = !v1_ff || adv2;
      v1_in        = adv1 ? req_valid : v1_ff;
      v2_in        = adv2 ? v1_ff : v2_ff;
      v3_in        = adv3 ? v2_ff : v3_ff;
      rsp_valid_in = adv4 ? v3_ff : rsp_valid_ff;
   end

   assign req_ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // stage 1: slab setup per axis
   rbst_axis #(
      .COORD_BITS (COORD_BITS)
   ) u_axis_x (
      .center  (req_box_center_x),
      .half    (req_half_width),
      .org     (req_ray_origin_x),
      .dir     (req_ray_dir_x),
      .ent_num (ent_x),
      .ext_num (ext_x),
      .den     (den_x),
      .flags   (flags_x)
   );

   rbst_axis #(
      .COORD_BITS (COORD_BITS)
   ) u_axis_y (
      .center  (req_box_center_y),
      .half    (req_half_height),
      .org     (req_ray_origin_y),
      .dir     (req_ray_dir_y),
      .ent_num (ent_y),
      .ext_num (ext_y),
      .den     (den_y),
      .flags   (flags_y)
   );

   // clamped entry misses when an active axis exits before the origin
   always_comb begin
      flags1_in.par_x      = flags_x.parallel;
      flags1_in.par_y      = flags_y.parallel;
      flags1_in.slab_miss  = flags_x.outside || flags_y.outside;
      flags1_in.clamp_miss = clamp_ff
                          && ((!flags_x.parallel && flags_x.exit_neg)
                           || (!flags_y.parallel && flags_y.exit_neg));
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         ent_x_ff  <= ent_x;
         ext_x_ff  <= ext_x;
         den_x_ff  <= den_x;
         ent_y_ff  <= ent_y;
         ext_y_ff  <= ext_y;
         den_y_ff  <= den_y;
         flags1_ff <= flags1_in;
      end
   end

   // stages 2 and 3: cross products, entry of one axis against exit of the other
   rbst_xmul #(.NUM_BITS (NumBits), .DEN_BITS (DenBits)) u_mul_ex_dy (
      .clock (clock), .load_part (adv2), .load_sum (adv3),
      .num (ent_x_ff), .den (den_y_ff), .prod (prod_ex_dy)
   );

   rbst_xmul #(.NUM_BITS (NumBits), .DEN_BITS (DenBits)) u_mul_ty_dx (
      .clock (clock), .load_part (adv2), .load_sum (adv3),
      .num (ext_y_ff), .den (den_x_ff), .prod (prod_ty_dx)
   );

   rbst_xmul #(.NUM_BITS (NumBits), .DEN_BITS (DenBits)) u_mul_ey_dx (
      .clock (clock), .load_part (adv2), .load_sum (adv3),
      .num (ent_y_ff), .den (den_x_ff), .prod (prod_ey_dx)
   );

   rbst_xmul #(.NUM_BITS (NumBits), .DEN_BITS (DenBits)) u_mul_tx_dy (
      .clock (clock), .load_part (adv2), .load_sum (adv3),
      .num (ext_x_ff), .den (den_y_ff), .prod (prod_tx_dy)
   );

   // status follows the products
   always_ff @(posedge clock) begin
      if (adv2) begin
         flags2_ff <= flags1_ff;
      end
      if (adv3) begin
         flags3_ff <= flags2_ff;
      end
   end

   // stage 4: no slab or clamp miss and, with no parallel axis, no entry above any exit
   always_comb begin
      hit_in = !flags3_ff.slab_miss && !flags3_ff.clamp_miss
            && (flags3_ff.par_x || flags3_ff.par_y
             || ((prod_ex_dy <= prod_ty_dx) && (prod_ey_dx <= prod_tx_dy)));
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         hit_ff <= hit_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = hit_ff;

   // checks
   `RBST_ASSERT_NEXT(a_accept_fills_stage1, clock, reset,
      req_valid && req_ready, v1_ff, "accepted item did not enter stage 1")
   `RBST_ASSERT_NOW(a_full_stall_blocks_input, clock, reset,
      v1_ff && v2_ff && v3_ff && rsp_valid_ff && !rsp_ready, !req_ready,
      "input taken while the pipeline is full and stalled")
   `RBST_ASSERT_NEXT(a_miss_gives_no_hit, clock, reset,
      v3_ff && adv4 && (flags3_ff.slab_miss || flags3_ff.clamp_miss),
      rsp_valid && !rsp_hit, "slab or clamp miss reported as hit")
   `RBST_ASSERT_NEXT(a_inside_parallel_hits, clock, reset,
      v3_ff && adv4 && flags3_ff.par_x && flags3_ff.par_y && !flags3_ff.slab_miss,
      rsp_valid && rsp_hit, "zero direction with origin inside did not hit")

endmodule

### src/rbst_axis.sv
`timescale 1ns / 1ps

module rbst_axis
   import rbst_pkg::*;
#(
   parameter int COORD_BITS = 32
) (
   input  logic signed [COORD_BITS-1:0] center,
   input  logic        [COORD_BITS-3:0] half,
   input  logic signed [COORD_BITS-1:0] org,
   input  logic signed [COORD_BITS-1:0] dir,
   output logic signed [COORD_BITS+1:0] ent_num,
   output logic signed [COORD_BITS+1:0] ext_num,
   output logic        [COORD_BITS-1:0] den,
   output axis_flags_type               flags
);

   localparam int NumBits = COORD_BITS + 2;

   logic signed [NumBits-1:0] center_e;
   logic signed [NumBits-1:0] half_e;
   logic signed [NumBits-1:0] org_e;
   logic signed [NumBits-1:0] lo;
   logic signed [NumBits-1:0] hi;
   logic                      dir_neg;
   logic                      dir_zero;

   // slab bounds at full width
   always_comb begin
      center_e = {{2{center[COORD_BITS-1]}}, center};
      half_e   = $signed({4'b0000, half});
      org_e    = {{2{org[COORD_BITS-1]}}, org};
      lo       = center_e - half_e;
      hi       = center_e + half_e;
   end

   // near and far chosen by direction sign, magnitude as denominator
   always_comb begin
      dir_neg  = dir[COORD_BITS-1];
      dir_zero = (dir == '0);
      if (dir_neg) begin
         ent_num = org_e - hi;
         ext_num = org_e - lo;
         den     = ~dir + 1'b1;
      end else begin
         ent_num = lo - org_e;
         ext_num = hi - org_e;
         den     = dir;
      end
      flags.parallel = dir_zero;
      flags.outside  = dir_zero && ((org_e < lo) || (org_e > hi));
      flags.exit_neg = ext_num[NumBits-1];
   end

endmodule

### src/rbst_xmul.sv
`timescale 1ns / 1ps

module rbst_xmul #(
   parameter int NUM_BITS = 34,
   parameter int DEN_BITS = 32
) (
   input  logic                                clock,
   input  logic                                load_part,
   input  logic                                load_sum,
   input  logic signed [NUM_BITS-1:0]          num,
   input  logic        [DEN_BITS-1:0]          den,
   output logic signed [NUM_BITS+DEN_BITS-1:0] prod
);

   localparam int SplitBits  = DEN_BITS / 2;
   localparam int DenHiBits  = DEN_BITS - SplitBits;
   localparam int NumHiBits  = NUM_BITS - SplitBits;
   localparam int ProdBits   = NUM_BITS + DEN_BITS;
   localparam int HhBits     = NumHiBits + DenHiBits + 1;
   localparam int HlBits     = NumHiBits + SplitBits + 1;
   localparam int LhBits     = SplitBits + DenHiBits;
   localparam int LlBits     = 2 * SplitBits;

   logic signed [NumHiBits-1:0] num_hi;
   logic        [SplitBits-1:0] num_lo;
   logic        [DenHiBits-1:0] den_hi;
   logic        [SplitBits-1:0] den_lo;

   logic signed [HhBits-1:0]    p_hh_in, p_hh_ff;
   logic signed [HlBits-1:0]    p_hl_in, p_hl_ff;
   logic        [LhBits-1:0]    p_lh_in, p_lh_ff;
   logic        [LlBits-1:0]    p_ll_in, p_ll_ff;
   logic        [ProdBits-1:0]  sum_in, sum_ff;

   // split both operands into halves, four narrow products
   always_comb begin
      num_hi  = num[NUM_BITS-1:SplitBits];
      num_lo  = num[SplitBits-1:0];
      den_hi  = den[DEN_BITS-1:SplitBits];
      den_lo  = den[SplitBits-1:0];
      p_hh_in = num_hi * $signed({1'b0, den_hi});
      p_hl_in = num_hi * $signed({1'b0, den_lo});
      p_lh_in = num_lo * den_hi;
      p_ll_in = num_lo * den_lo;
   end

   always_ff @(posedge clock) begin
      if (load_part) begin
         p_hh_ff <= p_hh_in;
         p_hl_ff <= p_hl_in;
         p_lh_ff <= p_lh_in;
         p_ll_ff <= p_ll_in;
      end
   end

   // recombine partials into the full signed product
   always_comb begin
      sum_in = ({{(ProdBits-HhBits){p_hh_ff[HhBits-1]}}, p_hh_ff} << (2 * SplitBits))
             + ({{(ProdBits-HlBits){p_hl_ff[HlBits-1]}}, p_hl_ff} << SplitBits)
             + ({{(ProdBits-LhBits){1'b0}}, p_lh_ff} << SplitBits)
             + {{(ProdBits-LlBits){1'b0}}, p_ll_ff};
   end

   always_ff @(posedge clock) begin
      if (load_sum) begin
         sum_ff <= sum_in;
      end
   end

   assign prod = $signed(sum_ff);

endmodule
